// ===== rtl/core/ffpa_pkg.sv =====
// ---------------------------------------------------------------------------
// ffpa_pkg
// Shared types, sizes and codes for the first-fit partition allocator.
// ---------------------------------------------------------------------------
package ffpa_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;

  // Widths fixed by the item fields
  localparam int MODE_W  = 2;
  localparam int REQ_W   = 16;
  localparam int STAT_W  = 3;
  localparam int PIDX_W  = 4;
  localparam int WASTE_W = 20;
  localparam int FREE_W  = 20;
  localparam int TOTAL_W = 21;

  // Derived sizes
  localparam int IDX_W   = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W   = $clog2(MAX_PARTITIONS + 1);
  localparam int SUM_RAW = SIZE_BITS + CNT_W;
  localparam int SUM_W   = (SUM_RAW > TOTAL_W) ? SUM_RAW : TOTAL_W;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_PLACED = 3'd0,
    ST_NOFIT  = 3'd1,
    ST_ADDED  = 3'd2,
    ST_FULL   = 3'd3,
    ST_ZERO   = 3'd4,
    ST_REPORT = 3'd5
  } status_t;

  // Request bundle from the sequencer to the partition table
  typedef struct packed {
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_size;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 use_en;
    logic [IDX_W-1:0]     use_addr;
  } tbl_req_t;

  // Low SIZE_BITS bits of the request, zero-extended where SIZE_BITS is wider
  function automatic logic [SIZE_BITS-1:0] trim_size(input logic [REQ_W-1:0] req);
    logic [31:0] ext;
    ext = 32'(req);
    return ext[SIZE_BITS-1:0];
  endfunction

  // Partition index folded into the result field width
  function automatic logic [PIDX_W-1:0] to_pidx(input logic [IDX_W-1:0] idx);
    logic [31:0] ext;
    ext = 32'(idx);
    return ext[PIDX_W-1:0];
  endfunction

endpackage

// ===== rtl/core/ffpa_table.sv =====
// ---------------------------------------------------------------------------
// ffpa_table
// Partition size memory (registered read) plus per-entry used flags.
// ---------------------------------------------------------------------------
module ffpa_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ffpa_pkg::tbl_req_t             req,
  output logic [ffpa_pkg::SIZE_BITS-1:0] rd_size,
  output logic                           rd_used
);

  logic [ffpa_pkg::SIZE_BITS-1:0]      size_mem [ffpa_pkg::MAX_PARTITIONS];
  logic [ffpa_pkg::SIZE_BITS-1:0]      rd_size_r;
  logic                                rd_used_r;
  logic [ffpa_pkg::MAX_PARTITIONS-1:0] used_r;

  // sizes: no reset, only entries below the fill count are ever read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      size_mem[req.wr_addr] <= req.wr_size;
    end
    if (req.rd_en) begin
      rd_size_r <= size_mem[req.rd_addr];
      rd_used_r <= used_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (req.wr_en) begin
        used_r[req.wr_addr] <= 1'b0;
      end
      if (req.use_en) begin
        used_r[req.use_addr] <= 1'b1;
      end
    end
  end

  assign rd_size = rd_size_r;
  assign rd_used = rd_used_r;

endmodule

// ===== rtl/core/first_fit_partition_allocator.sv =====
// ---------------------------------------------------------------------------
// first_fit_partition_allocator
// Fixed-partition table with first-fit job placement and running totals.
// ---------------------------------------------------------------------------
// One item in, one result out. An add item appends a partition; an allocate
// item scans the table in order of addition and places the job in the first
// free partition that is large enough; a report item just returns totals.
// Every result carries wastage, free and combined totals. An allocate
// scans the N partitions in the table (16 at most) with one size read
// and one compare per cycle through a single subtractor; each entry is
// compared in the cycle after its registered memory read. in_ready is
// high only while the sequencer is idle; a finished result sits in the
// output register and the next item is still taken while it waits. No
// clearing pass after reset.
// ---------------------------------------------------------------------------
module first_fit_partition_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ffpa_pkg::MODE_W-1:0]  in_mode,
  input  logic [ffpa_pkg::REQ_W-1:0]   in_request_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ffpa_pkg::STAT_W-1:0]  out_status,
  output logic [ffpa_pkg::PIDX_W-1:0]  out_partition_index,
  output logic [ffpa_pkg::WASTE_W-1:0] out_wastage_total,
  output logic [ffpa_pkg::FREE_W-1:0]  out_free_total,
  output logic [ffpa_pkg::TOTAL_W-1:0] out_combined_total
);

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SCAN     = 5'b00100,
    S_COMMIT   = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Captured item
  logic [ffpa_pkg::MODE_W-1:0]    mode_r;
  logic [ffpa_pkg::SIZE_BITS-1:0] req_r;

  // Architectural state
  logic [ffpa_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [ffpa_pkg::SUM_W-1:0] wastage_r, wastage_nxt;
  logic [ffpa_pkg::SUM_W-1:0] free_r, free_nxt;

  // Scan pipeline
  logic [ffpa_pkg::CNT_W-1:0]     issue_cnt_r, issue_cnt_nxt;
  logic [ffpa_pkg::CNT_W-1:0]     data_cnt_r, data_cnt_nxt;
  logic                           data_vld_r, data_vld_nxt;
  logic [ffpa_pkg::IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [ffpa_pkg::SIZE_BITS-1:0] hit_size_r, hit_size_nxt;
  logic [ffpa_pkg::SIZE_BITS-1:0] hit_diff_r, hit_diff_nxt;

  // Pending result of the current item
  ffpa_pkg::status_t          res_status_r, res_status_nxt;
  logic [ffpa_pkg::IDX_W-1:0] res_idx_r, res_idx_nxt;

  // Output register
  logic                          out_valid_r;
  logic [ffpa_pkg::STAT_W-1:0]   out_status_r;
  logic [ffpa_pkg::PIDX_W-1:0]   out_pidx_r;
  logic [ffpa_pkg::WASTE_W-1:0]  out_waste_r;
  logic [ffpa_pkg::FREE_W-1:0]   out_free_r;
  logic [ffpa_pkg::TOTAL_W-1:0]  out_total_r;

  ffpa_pkg::tbl_req_t             tbl_req;
  logic [ffpa_pkg::SIZE_BITS-1:0] rd_size;
  logic                           rd_used;

  logic                           in_acc;
  logic                           out_free_slot;
  logic                           issue_vld;
  logic [ffpa_pkg::SIZE_BITS:0]   diff;       // shared subtractor, MSB is borrow
  logic                           hit;
  logic                           last;
  logic                           req_zero;
  logic                           tbl_full;
  logic [ffpa_pkg::SUM_W-1:0]     sum_all;

  assign in_ready      = (state_r == S_IDLE);
  assign in_acc        = in_valid && in_ready;
  assign out_free_slot = !out_valid_r || out_ready;

  assign req_zero  = (req_r == '0);
  assign tbl_full  = (count_r == ffpa_pkg::CNT_W'(ffpa_pkg::MAX_PARTITIONS));
  assign issue_vld = (issue_cnt_r < count_r);

  // size read last cycle minus job size; no borrow means it fits
  assign diff = {1'b0, rd_size} - {1'b0, req_r};
  assign hit  = data_vld_r && !rd_used && !diff[ffpa_pkg::SIZE_BITS];
  assign last = data_vld_r && ((data_cnt_r + ffpa_pkg::CNT_W'(1)) == count_r);

  assign sum_all = wastage_r + free_r;

  ffpa_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .rd_size (rd_size),
    .rd_used (rd_used)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    wastage_nxt    = wastage_r;
    free_nxt       = free_r;
    issue_cnt_nxt  = issue_cnt_r;
    data_cnt_nxt   = data_cnt_r;
    data_vld_nxt   = 1'b0;
    hit_idx_nxt    = hit_idx_r;
    hit_size_nxt   = hit_size_r;
    hit_diff_nxt   = hit_diff_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;

    tbl_req          = '0;
    tbl_req.wr_addr  = count_r[ffpa_pkg::IDX_W-1:0];
    tbl_req.wr_size  = req_r;
    tbl_req.rd_addr  = issue_cnt_r[ffpa_pkg::IDX_W-1:0];
    tbl_req.use_addr = hit_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_idx_nxt = '0;
        state_nxt   = S_DONE;
        case (mode_r)
          ffpa_pkg::MODE_ADD: begin
            if (req_zero) begin
              res_status_nxt = ffpa_pkg::ST_ZERO;
            end else if (tbl_full) begin
              res_status_nxt = ffpa_pkg::ST_FULL;
            end else begin
              tbl_req.wr_en  = 1'b1;
              count_nxt      = count_r + ffpa_pkg::CNT_W'(1);
              free_nxt       = free_r + ffpa_pkg::SUM_W'(req_r);
              res_status_nxt = ffpa_pkg::ST_ADDED;
              res_idx_nxt    = count_r[ffpa_pkg::IDX_W-1:0];
            end
          end
          ffpa_pkg::MODE_ALLOC: begin
            if (req_zero) begin
              res_status_nxt = ffpa_pkg::ST_ZERO;
            end else if (count_r == '0) begin
              res_status_nxt = ffpa_pkg::ST_NOFIT;
            end else begin
              issue_cnt_nxt = '0;
              state_nxt     = S_SCAN;
            end
          end
          default: begin
            // report, and the unused mode code behaves the same
            res_status_nxt = ffpa_pkg::ST_REPORT;
          end
        endcase
      end

      S_SCAN: begin
        // read entry k while comparing entry k-1
        tbl_req.rd_en = issue_vld;
        if (issue_vld) begin
          issue_cnt_nxt = issue_cnt_r + ffpa_pkg::CNT_W'(1);
        end
        data_vld_nxt = issue_vld;
        data_cnt_nxt = issue_cnt_r;
        if (hit) begin
          hit_idx_nxt  = data_cnt_r[ffpa_pkg::IDX_W-1:0];
          hit_size_nxt = rd_size;
          hit_diff_nxt = diff[ffpa_pkg::SIZE_BITS-1:0];
          data_vld_nxt = 1'b0;
          state_nxt    = S_COMMIT;
        end else if (last) begin
          res_status_nxt = ffpa_pkg::ST_NOFIT;
          res_idx_nxt    = '0;
          data_vld_nxt   = 1'b0;
          state_nxt      = S_DONE;
        end
      end

      S_COMMIT: begin
        tbl_req.use_en = 1'b1;
        wastage_nxt    = wastage_r + ffpa_pkg::SUM_W'(hit_diff_r);
        free_nxt       = free_r - ffpa_pkg::SUM_W'(hit_size_r);
        res_status_nxt = ffpa_pkg::ST_PLACED;
        res_idx_nxt    = hit_idx_r;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (out_free_slot) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wastage_r   <= '0;
      free_r      <= '0;
      data_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      wastage_r  <= wastage_nxt;
      free_r     <= free_nxt;
      data_vld_r <= data_vld_nxt;
      if (state_r == S_DONE && out_free_slot) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      req_r  <= ffpa_pkg::trim_size(in_request_size);
    end
    issue_cnt_r  <= issue_cnt_nxt;
    data_cnt_r   <= data_cnt_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_size_r   <= hit_size_nxt;
    hit_diff_r   <= hit_diff_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    if (state_r == S_DONE && out_free_slot) begin
      out_status_r <= res_status_r;
      out_pidx_r   <= ffpa_pkg::to_pidx(res_idx_r);
      out_waste_r  <= wastage_r[ffpa_pkg::WASTE_W-1:0];
      out_free_r   <= free_r[ffpa_pkg::FREE_W-1:0];
      out_total_r  <= sum_all[ffpa_pkg::TOTAL_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_partition_index = out_pidx_r;
  assign out_wastage_total   = out_waste_r;
  assign out_free_total      = out_free_r;
  assign out_combined_total  = out_total_r;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ffpa_pkg::CNT_W'(ffpa_pkg::MAX_PARTITIONS))
    else $error("partition count beyond table size");

  a_hit_commits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit) |=> (state_r == S_COMMIT))
    else $error("scan hit did not commit");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_DISPATCH))
    else $error("accepted item not dispatched");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && data_vld_r) |-> (data_cnt_r < count_r))
    else $error("scan compared an entry beyond the fill count");

endmodule

// ===== bench/first_fit_partition_allocator_test.sv =====
// ---------------------------------------------------------------------------
// first_fit_partition_allocator_test
// Self-checking bench for the first-fit partition allocator: a queued item
// driver and a result monitor, each with random idle cycles, checked against
// a bit-true model of the partition table kept in the bench.
// ---------------------------------------------------------------------------
module first_fit_partition_allocator_test;

  // Mode 3 has no name in the package; the block treats it as a report.
  localparam logic [ffpa_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_AT      = 250;  // result count that starts the long stall
  localparam int HOLD_LEN     = 90;   // cycles out_ready stays low there
  localparam int DRAIN_AT     = 450;  // item count where the sender waits for empty
  localparam int CALM_LO      = 600;  // no-idle window, both sides
  localparam int CALM_HI      = 680;
  localparam int TAIL_CYCLES  = 40;   // longer than the worst allocate latency
  localparam int IDLE_LIMIT   = 2000; // cycles with no handshake before giving up

  typedef struct {
    logic [ffpa_pkg::MODE_W-1:0] mode;
    logic [ffpa_pkg::REQ_W-1:0]  size;
  } request_t;

  typedef struct {
    ffpa_pkg::status_t             status;
    logic [ffpa_pkg::PIDX_W-1:0]   pidx;
    logic [ffpa_pkg::WASTE_W-1:0]  waste;
    logic [ffpa_pkg::FREE_W-1:0]   free;
    logic [ffpa_pkg::TOTAL_W-1:0]  total;
  } answer_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ffpa_pkg::MODE_W-1:0]   in_mode = ffpa_pkg::MODE_ADD;
  logic [ffpa_pkg::REQ_W-1:0]    in_request_size = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ffpa_pkg::STAT_W-1:0]   out_status;
  logic [ffpa_pkg::PIDX_W-1:0]   out_partition_index;
  logic [ffpa_pkg::WASTE_W-1:0]  out_wastage_total;
  logic [ffpa_pkg::FREE_W-1:0]   out_free_total;
  logic [ffpa_pkg::TOTAL_W-1:0]  out_combined_total;

  request_t    request_q[$];   // items still to be offered
  answer_t     answer_q[$];    // results owed by the block, oldest first
  int unsigned gen_sizes[$];   // partition sizes queued so far, for job sizing

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned idle_cycles  = 0;

  // Shadow copy of the partition table
  logic [ffpa_pkg::SIZE_BITS-1:0] tbl_size [ffpa_pkg::MAX_PARTITIONS];
  logic [ffpa_pkg::SIZE_BITS-1:0] tbl_job  [ffpa_pkg::MAX_PARTITIONS];
  int unsigned                    tbl_count = 0;
  logic [63:0]                    waste_acc = '0;
  logic [63:0]                    free_acc  = '0;

  first_fit_partition_allocator u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_request_size     (in_request_size),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_partition_index (out_partition_index),
    .out_wastage_total   (out_wastage_total),
    .out_free_total      (out_free_total),
    .out_combined_total  (out_combined_total)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one accepted item to the shadow table and queue the result it owes.
  task automatic first_fit_step(input logic [ffpa_pkg::MODE_W-1:0] mode,
                                input logic [ffpa_pkg::REQ_W-1:0] req);
    logic [ffpa_pkg::SIZE_BITS-1:0] sz;
    ffpa_pkg::status_t              st;
    int unsigned                    idx;
    bit                             found;
    answer_t                        ans;
    sz    = ffpa_pkg::SIZE_BITS'(req);
    st    = ffpa_pkg::ST_REPORT;
    idx   = 0;
    found = 1'b0;
    if (mode == ffpa_pkg::MODE_ADD) begin
      if (sz == '0) begin
        st = ffpa_pkg::ST_ZERO;
      end else if (tbl_count >= ffpa_pkg::MAX_PARTITIONS) begin
        st = ffpa_pkg::ST_FULL;
      end else begin
        idx           = tbl_count;
        tbl_size[idx] = sz;
        tbl_job[idx]  = '0;
        tbl_count     = tbl_count + 1;
        free_acc      = free_acc + 64'(sz);
        st            = ffpa_pkg::ST_ADDED;
      end
    end else if (mode == ffpa_pkg::MODE_ALLOC) begin
      if (sz == '0) begin
        st = ffpa_pkg::ST_ZERO;
      end else begin
        // first free entry, in order of addition, that is big enough
        for (int i = 0; i < tbl_count; i++) begin
          if (!found && tbl_job[i] == '0 && tbl_size[i] >= sz) begin
            found      = 1'b1;
            idx        = i;
            tbl_job[i] = sz;
            waste_acc  = waste_acc + 64'(tbl_size[i] - sz);
            free_acc   = free_acc - 64'(tbl_size[i]);
          end
        end
        st = found ? ffpa_pkg::ST_PLACED : ffpa_pkg::ST_NOFIT;
        if (!found) idx = 0;
      end
    end
    // MODE_REPORT and the spare mode leave everything as is
    ans.status = st;
    ans.pidx   = ffpa_pkg::PIDX_W'(idx);
    ans.waste  = ffpa_pkg::WASTE_W'(waste_acc);
    ans.free   = ffpa_pkg::FREE_W'(free_acc);
    ans.total  = ffpa_pkg::TOTAL_W'(waste_acc + free_acc);
    answer_q.push_back(ans);
  endtask

  task automatic queue_request(input logic [ffpa_pkg::MODE_W-1:0] mode,
                               input logic [ffpa_pkg::REQ_W-1:0] size);
    request_t r;
    r.mode = mode;
    r.size = size;
    request_q.push_back(r);
    if (mode == ffpa_pkg::MODE_ADD && size != '0) gen_sizes.push_back(size);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: offers queued items, one idle gap drawn at random per item, none in the calm window.
  always @(posedge clk) begin : drive_proc
    request_t nxt;
    logic     busy;
    logic     holding;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_mode         <= ffpa_pkg::MODE_ADD;
      in_request_size <= '0;
      gap_left        = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        first_fit_step(in_mode, in_request_size);
        items_sent++;
        busy     = 1'b0;
        gap_left = (items_sent >= CALM_LO && items_sent < CALM_HI) ?
                   0 : $urandom_range(0, 3);
      end
      // once mid-run, hold the next item until the block has answered all
      holding = (items_sent == DRAIN_AT) && (answer_q.size() != 0);
      if (!busy) begin
        if (request_q.size() != 0 && gap_left == 0 && !holding) begin
          nxt              = request_q.pop_front();
          in_valid        <= 1'b1;
          in_mode         <= nxt.mode;
          in_request_size <= nxt.size;
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Monitor: takes results, compares with the oldest owed answer, then
  // drops out_ready for a gap drawn at random, none in the calm window; one long stall fills the block up.
  always @(posedge clk) begin : watch_proc
    answer_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $error("result with nothing owed: status %0d", out_status);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("partition_index", 32'(want.pidx), 32'(out_partition_index));
          check_field("wastage_total", 32'(want.waste), 32'(out_wastage_total));
          check_field("free_total", 32'(want.free), 32'(out_free_total));
          check_field("combined_total", 32'(want.total), 32'(out_combined_total));
        end
        results_seen++;
        if (results_seen == HOLD_AT)
          stall_left = HOLD_LEN;
        else if (results_seen >= CALM_LO && results_seen < CALM_HI)
          stall_left = 0;
        else
          stall_left = $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake means the block is stuck.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : run_ctl
    int unsigned r;
    int unsigned base;
    int unsigned sz;

    // Directed: reports, spare mode, zero requests, empty-table miss,
    // extreme sizes, first fit skipping a small entry, used-entry skip.
    queue_request(ffpa_pkg::MODE_REPORT, 16'h1234);
    queue_request(MODE_SPARE,            16'hFFFF);
    queue_request(ffpa_pkg::MODE_ADD,    16'h0000);    // zero add
    queue_request(ffpa_pkg::MODE_ALLOC,  16'h0000);    // zero allocate
    queue_request(ffpa_pkg::MODE_ALLOC,  16'h0001);    // nothing in the table yet
    queue_request(ffpa_pkg::MODE_ADD,    16'hFFFF);
    queue_request(ffpa_pkg::MODE_ADD,    16'h0001);
    queue_request(ffpa_pkg::MODE_ALLOC,  16'hFFFF);    // exact fit, no wastage
    queue_request(ffpa_pkg::MODE_ALLOC,  16'h0001);
    queue_request(ffpa_pkg::MODE_ALLOC,  16'h0001);    // all entries used
    queue_request(ffpa_pkg::MODE_ADD,    16'd100);
    queue_request(ffpa_pkg::MODE_ADD,    16'd300);
    queue_request(ffpa_pkg::MODE_ALLOC,  16'd200);     // skips the 100 entry
    queue_request(ffpa_pkg::MODE_ALLOC,  16'd50);      // lands in the 100 entry
    queue_request(ffpa_pkg::MODE_ADD,    16'hAAAA);
    queue_request(ffpa_pkg::MODE_ADD,    16'h5555);
    queue_request(ffpa_pkg::MODE_ALLOC,  16'h5556);    // only the 0xAAAA entry fits
    queue_request(ffpa_pkg::MODE_ALLOC,  16'h5556);    // no fit left
    queue_request(ffpa_pkg::MODE_ADD,    16'h0000);
    queue_request(MODE_SPARE,            16'h0000);
    queue_request(ffpa_pkg::MODE_REPORT, 16'h0000);

    // Random: adds are rare since the table only grows, so it fills
    // mid-run and the full case gets hit; job sizes lean on known sizes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        case ($urandom_range(0, 7))
          0:       sz = 16'hFFFF;
          1, 2:    sz = $urandom_range(1, 255);
          default: sz = $urandom_range(1, 65535);
        endcase
        queue_request(ffpa_pkg::MODE_ADD, ffpa_pkg::REQ_W'(sz));
      end else if (r < 70) begin
        if (gen_sizes.size() != 0 && $urandom_range(0, 1)) begin
          base = gen_sizes[$urandom_range(0, gen_sizes.size() - 1)];
          case ($urandom_range(0, 3))
            0:       sz = base;
            1:       sz = (base < 65535) ? base + 1 : base;
            default: sz = $urandom_range(1, base);
          endcase
        end else if ($urandom_range(0, 3) == 0) begin
          sz = $urandom_range(1, 255);
        end else begin
          sz = $urandom_range(1, 65535);
        end
        queue_request(ffpa_pkg::MODE_ALLOC, ffpa_pkg::REQ_W'(sz));
      end else if (r < 78) begin
        queue_request($urandom_range(0, 1) ? ffpa_pkg::MODE_ALLOC : ffpa_pkg::MODE_ADD,
                      '0);
      end else if (r < 92) begin
        queue_request(ffpa_pkg::MODE_REPORT,
                      ffpa_pkg::REQ_W'($urandom_range(0, 65535)));
      end else begin
        queue_request(MODE_SPARE, ffpa_pkg::REQ_W'($urandom_range(0, 65535)));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid || !rst_n) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== first_fit_partition_allocator.f =====
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_table.sv
rtl/core/first_fit_partition_allocator.sv
bench/first_fit_partition_allocator_test.sv
